// File: src/drive_command_watchdog_macros.svh
// Assertion macros used by the drive command watchdog checker.
`ifndef DRIVE_COMMAND_WATCHDOG_MACROS_SVH
`define DRIVE_COMMAND_WATCHDOG_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DCW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DCW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/dcw_pkg.sv
// Types and codes of the drive command watchdog.
`default_nettype none

package dcw_pkg;

	localparam int SP_PORT_BITS   = 48;
	localparam int SP_MAX_BITS    = 64;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam int TOTAL_BITS     = 32;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_TICKS = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LED_PERIOD    = 1'd1;

	// Register reset values
	localparam logic [CFG_DATA_BITS-1:0] TIMEOUT_RESET = 16'd10;
	localparam logic [CFG_DATA_BITS-1:0] LED_RESET     = 16'd50;

	// Received command codes
	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_COAST    = 3'd1;
	localparam logic [2:0] CMD_BRAKE    = 3'd2;
	localparam logic [2:0] CMD_VELOCITY = 3'd3;
	localparam logic [2:0] CMD_HEADING  = 3'd4;

	// Latched modes
	localparam logic [1:0] MODE_COAST    = 2'd0;
	localparam logic [1:0] MODE_BRAKE    = 2'd1;
	localparam logic [1:0] MODE_VELOCITY = 2'd2;
	localparam logic [1:0] MODE_HEADING  = 2'd3;

	// Receive actions
	localparam logic [1:0] RX_NONE  = 2'd0;
	localparam logic [1:0] RX_STOP  = 2'd1;
	localparam logic [1:0] RX_BRAKE = 2'd2;

	// Drive actions
	localparam logic [1:0] DRV_RAMP     = 2'd0;
	localparam logic [1:0] DRV_VELOCITY = 2'd1;
	localparam logic [1:0] DRV_HEADING  = 2'd2;

	typedef struct packed {
		logic                    tick_due;
		logic                    cmd_valid;
		logic [2:0]              command;
		logic [SP_PORT_BITS-1:0] setpoint_in;
	} in_item_t;

	typedef struct packed {
		logic                    pid_reset;
		logic [1:0]              rx_action;
		logic                    timeout_stop;
		logic [1:0]              drive_action;
		logic [SP_PORT_BITS-1:0] setpoint_out;
		logic                    led_toggle;
		logic                    link_online;
		logic [TOTAL_BITS-1:0]   timeouts_seen;
	} out_item_t;

endpackage

`default_nettype wire

// File: src/dcw_led_div.sv
// Status LED tick divider: pulses once every led_period ticks.
`default_nettype none

module dcw_led_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              advance,
	input  wire logic [dcw_pkg::CFG_DATA_BITS-1:0] period,
	output logic                                   toggle
);

	logic [dcw_pkg::CFG_DATA_BITS-1:0] count_q;
	logic [dcw_pkg::CFG_DATA_BITS-1:0] count_inc;

	// Step the count; fire and restart when it reaches the period
	always_comb begin
		count_inc = count_q + 1'b1;
		toggle    = (count_inc >= period);
	end

	// Advance only on an accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			count_q <= toggle ? '0 : count_inc;
		end
	end

endmodule

`default_nettype wire

// File: src/drive_command_watchdog.sv
// Drive command watchdog: per-tick link supervisor with a registered result.
// A tick item's result is registered and shows in out_data the cycle after acceptance.
// Throughput: one item per cycle unless a result waits with out_ready low; a new item
// enters as the previous result is taken. Items with tick_due low give no result.
// Reset (arst_n low, asynchronous): counters and flags clear, mode coast,
// timeout_ticks 10, led_period 50, no result pending.
`default_nettype none

module drive_command_watchdog #(
	parameter int SETPOINT_BITS = 48,
	parameter int TICK_BITS     = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire dcw_pkg::in_item_t                  in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output dcw_pkg::out_item_t                      out_data,
	input  wire logic                               cfg_we,
	input  wire logic [dcw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [dcw_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	// Configuration
	logic [dcw_pkg::CFG_DATA_BITS-1:0] timeout_q;
	logic [dcw_pkg::CFG_DATA_BITS-1:0] led_period_q;

	// Link state
	logic [TICK_BITS-1:0]           tick_q;
	logic [TICK_BITS-1:0]           last_rx_q;
	logic                           online_q;
	logic                           enabled_q;
	logic [1:0]                     mode_q;
	logic [SETPOINT_BITS-1:0]       setpoint_q;
	logic [dcw_pkg::TOTAL_BITS-1:0] total_q;

	// Result register
	logic               out_valid_q;
	dcw_pkg::out_item_t out_data_q;

	// Next-state and result terms
	logic                           accept;
	logic                           tick_acc;
	logic                           led_toggle;
	logic [TICK_BITS-1:0]           tick_n;
	logic [TICK_BITS-1:0]           last_rx_n;
	logic                           online_rx;
	logic                           online_n;
	logic                           enabled_rx;
	logic                           enabled_n;
	logic [1:0]                     mode_n;
	logic [SETPOINT_BITS-1:0]       setpoint_n;
	logic [dcw_pkg::TOTAL_BITS-1:0] total_n;
	logic                           pid_reset;
	logic [1:0]                     rx_action;
	logic                           timed_out;
	logic                           timeout_stop;
	logic [1:0]                     drive_action;
	logic [TICK_BITS-1:0]           since_rx;
	logic [dcw_pkg::SP_MAX_BITS-1:0] sp_in_wide;
	logic [dcw_pkg::SP_MAX_BITS-1:0] sp_out_wide;

	// Take an item whenever the result slot is free or being emptied
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign tick_acc  = accept && in_data.tick_due;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	dcw_led_div u_led (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (tick_acc),
		.period  (led_period_q),
		.toggle  (led_toggle)
	);

	// Fit the setpoint between the port width and the stored width
	assign sp_in_wide  = dcw_pkg::SP_MAX_BITS'(in_data.setpoint_in);
	assign sp_out_wide = dcw_pkg::SP_MAX_BITS'(setpoint_n);

	// Apply the received command, then the timeout check, then pick the drive action
	always_comb begin
		tick_n       = tick_q + 1'b1;
		last_rx_n    = last_rx_q;
		online_rx    = online_q;
		enabled_rx   = enabled_q;
		mode_n       = mode_q;
		setpoint_n   = setpoint_q;
		pid_reset    = 1'b0;
		rx_action    = dcw_pkg::RX_NONE;
		if (in_data.cmd_valid) begin
			last_rx_n = tick_n;
			pid_reset = !online_q;
			online_rx = 1'b1;
			unique case (in_data.command)
				dcw_pkg::CMD_COAST: begin
					mode_n     = dcw_pkg::MODE_COAST;
					rx_action  = dcw_pkg::RX_STOP;
					enabled_rx = 1'b0;
				end
				dcw_pkg::CMD_BRAKE: begin
					mode_n     = dcw_pkg::MODE_BRAKE;
					rx_action  = dcw_pkg::RX_BRAKE;
					enabled_rx = 1'b0;
				end
				dcw_pkg::CMD_VELOCITY, dcw_pkg::CMD_HEADING: begin
					mode_n     = (in_data.command == dcw_pkg::CMD_VELOCITY) ?
					             dcw_pkg::MODE_VELOCITY : dcw_pkg::MODE_HEADING;
					setpoint_n = sp_in_wide[SETPOINT_BITS-1:0];
					enabled_rx = 1'b1;
				end
				default: begin
					// none or unknown code: stamp and go online, latch nothing
				end
			endcase
		end

		since_rx     = tick_n - last_rx_n;
		timed_out    = !online_rx || (since_rx > TICK_BITS'(timeout_q));
		timeout_stop = timed_out && enabled_rx;
		enabled_n    = enabled_rx && !timeout_stop;
		online_n     = online_rx && !timeout_stop;
		total_n      = timeout_stop ? total_q + 1'b1 : total_q;

		drive_action = dcw_pkg::DRV_RAMP;
		if (!timed_out && enabled_rx) begin
			unique case (mode_n)
				dcw_pkg::MODE_VELOCITY: drive_action = dcw_pkg::DRV_VELOCITY;
				dcw_pkg::MODE_HEADING:  drive_action = dcw_pkg::DRV_HEADING;
				dcw_pkg::MODE_COAST,
				dcw_pkg::MODE_BRAKE:    drive_action = dcw_pkg::DRV_RAMP;
			endcase
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= dcw_pkg::TIMEOUT_RESET;
			led_period_q <= dcw_pkg::LED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dcw_pkg::CFG_TIMEOUT_TICKS: timeout_q    <= cfg_data;
				dcw_pkg::CFG_LED_PERIOD:    led_period_q <= cfg_data;
			endcase
		end
	end

	// Advance link state on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q     <= '0;
			last_rx_q  <= '0;
			online_q   <= 1'b0;
			enabled_q  <= 1'b0;
			mode_q     <= dcw_pkg::MODE_COAST;
			setpoint_q <= '0;
			total_q    <= '0;
		end else if (tick_acc) begin
			tick_q     <= tick_n;
			last_rx_q  <= last_rx_n;
			online_q   <= online_n;
			enabled_q  <= enabled_n;
			mode_q     <= mode_n;
			setpoint_q <= setpoint_n;
			total_q    <= total_n;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result item
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			out_data_q.pid_reset     <= pid_reset;
			out_data_q.rx_action     <= rx_action;
			out_data_q.timeout_stop  <= timeout_stop;
			out_data_q.drive_action  <= drive_action;
			out_data_q.setpoint_out  <= sp_out_wide[dcw_pkg::SP_PORT_BITS-1:0];
			out_data_q.led_toggle    <= led_toggle;
			out_data_q.link_online   <= online_n;
			out_data_q.timeouts_seen <= total_n;
		end
	end

endmodule

`default_nettype wire

// File: src/dcw_checker.sv
// Port-level checks of the drive command watchdog, bound to its top level.
`default_nettype none

`include "drive_command_watchdog_macros.svh"

module dcw_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire dcw_pkg::out_item_t out_data
);

	// A stalled result item stays put
	`DCW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// Input is refused only while a result waits
	`DCW_ASSERT_NOW(a_ready_free, !in_ready, out_valid, "input refused with empty result slot")

	// A link that just came online cannot time out on the same tick
	`DCW_ASSERT_NOW(a_pid_online, out_valid && out_data.pid_reset, out_data.link_online && !out_data.timeout_stop, "pid reset without online link")

	// Coast or brake disables output and keeps the link up
	`DCW_ASSERT_NOW(a_rx_ramp, out_valid && (out_data.rx_action != dcw_pkg::RX_NONE), out_data.link_online && (out_data.drive_action == dcw_pkg::DRV_RAMP), "stop or brake with active drive")

	// A failsafe stop takes the link offline and ramps the motor
	`DCW_ASSERT_NOW(a_timeout_off, out_valid && out_data.timeout_stop, !out_data.link_online && (out_data.drive_action == dcw_pkg::DRV_RAMP), "timeout stop left link active")

endmodule

bind drive_command_watchdog dcw_checker u_dcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the drive command watchdog: predicted tick reports vs. DUT.
`timescale 1ns / 100ps

module testbench;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int LONG_HOLD    = 80;
	localparam int PRINT_LIMIT  = 50;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	dcw_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	dcw_pkg::out_item_t out_data;
	logic               cfg_we    = 1'b0;
	logic [dcw_pkg::CFG_INDEX_BITS-1:0] cfg_index = dcw_pkg::CFG_TIMEOUT_TICKS;
	logic [dcw_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// Predicted watchdog state and register copies
	logic [31:0] wd_tick        = '0;
	logic [31:0] wd_last_rx     = '0;
	logic [15:0] wd_led_count   = '0;
	logic        wd_online      = 1'b0;
	logic        wd_enabled     = 1'b0;
	logic [1:0]  wd_mode        = dcw_pkg::MODE_COAST;
	logic [47:0] wd_setpoint    = '0;
	logic [31:0] wd_timeouts    = '0;
	logic [15:0] reg_timeout    = dcw_pkg::TIMEOUT_RESET;
	logic [15:0] reg_led_period = dcw_pkg::LED_RESET;

	dcw_pkg::out_item_t expected_ticks[$];

	int  mismatches         = 0;
	int  ticks_sent         = 0;
	int  cycle_count        = 0;
	int  hold_left          = 0;
	int  stall_left         = 0;
	bit  hold_request       = 1'b0;
	bit  sender_gaps_on     = 1'b1;
	bit  receiver_stalls_on = 1'b1;

	drive_command_watchdog dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Count one mismatch and print its line, up to PRINT_LIMIT lines
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
	endtask

	// Advance the predicted watchdog by one tick item and queue its report; skip non-tick items
	task automatic supervise_tick(dcw_pkg::in_item_t item);
		dcw_pkg::out_item_t rep;
		logic               timed_out;
		if (!item.tick_due)
			return;
		rep = '0;
		wd_tick = wd_tick + 32'd1;
		wd_led_count = wd_led_count + 16'd1;
		if (wd_led_count >= reg_led_period) begin
			wd_led_count = '0;
			rep.led_toggle = 1'b1;
		end
		// Stamp the command and latch its mode; none or unknown codes only stamp and bring the link up
		if (item.cmd_valid) begin
			wd_last_rx = wd_tick;
			if (!wd_online)
				rep.pid_reset = 1'b1;
			wd_online = 1'b1;
			case (item.command)
				dcw_pkg::CMD_COAST: begin
					wd_mode = dcw_pkg::MODE_COAST;
					rep.rx_action = dcw_pkg::RX_STOP;
					wd_enabled = 1'b0;
				end
				dcw_pkg::CMD_BRAKE: begin
					wd_mode = dcw_pkg::MODE_BRAKE;
					rep.rx_action = dcw_pkg::RX_BRAKE;
					wd_enabled = 1'b0;
				end
				dcw_pkg::CMD_VELOCITY, dcw_pkg::CMD_HEADING: begin
					wd_mode = (item.command == dcw_pkg::CMD_VELOCITY) ?
						dcw_pkg::MODE_VELOCITY : dcw_pkg::MODE_HEADING;
					wd_setpoint = item.setpoint_in;
					wd_enabled = 1'b1;
				end
				default: ;
			endcase
		end
		// Failsafe on offline link or stale command, modular tick difference
		timed_out = !wd_online || ((wd_tick - wd_last_rx) > {16'd0, reg_timeout});
		if (timed_out) begin
			if (wd_enabled) begin
				rep.timeout_stop = 1'b1;
				wd_enabled = 1'b0;
				wd_online = 1'b0;
				wd_timeouts = wd_timeouts + 32'd1;
			end
			rep.drive_action = dcw_pkg::DRV_RAMP;
		end else if (wd_enabled && wd_mode == dcw_pkg::MODE_VELOCITY) begin
			rep.drive_action = dcw_pkg::DRV_VELOCITY;
		end else if (wd_enabled && wd_mode == dcw_pkg::MODE_HEADING) begin
			rep.drive_action = dcw_pkg::DRV_HEADING;
		end else begin
			rep.drive_action = dcw_pkg::DRV_RAMP;
		end
		rep.setpoint_out = wd_setpoint;
		rep.link_online = wd_online;
		rep.timeouts_seen = wd_timeouts;
		expected_ticks.push_back(rep);
	endtask

	task automatic compare_result(dcw_pkg::out_item_t got, dcw_pkg::out_item_t want);
		if (got.pid_reset !== want.pid_reset)
			report_mismatch("pid_reset", 64'(got.pid_reset), 64'(want.pid_reset));
		if (got.rx_action !== want.rx_action)
			report_mismatch("rx_action", 64'(got.rx_action), 64'(want.rx_action));
		if (got.timeout_stop !== want.timeout_stop)
			report_mismatch("timeout_stop", 64'(got.timeout_stop), 64'(want.timeout_stop));
		if (got.drive_action !== want.drive_action)
			report_mismatch("drive_action", 64'(got.drive_action), 64'(want.drive_action));
		if (got.setpoint_out !== want.setpoint_out)
			report_mismatch("setpoint_out", 64'(got.setpoint_out), 64'(want.setpoint_out));
		if (got.led_toggle !== want.led_toggle)
			report_mismatch("led_toggle", 64'(got.led_toggle), 64'(want.led_toggle));
		if (got.link_online !== want.link_online)
			report_mismatch("link_online", 64'(got.link_online), 64'(want.link_online));
		if (got.timeouts_seen !== want.timeouts_seen)
			report_mismatch("timeouts_seen", 64'(got.timeouts_seen),
				64'(want.timeouts_seen));
	endtask

	// Check each accepted result against the oldest predicted report
	always @(posedge clk) begin : result_check
		dcw_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("result with no tick pending", 64'(out_data.timeouts_seen), '0);
			end else begin
				want = expected_ticks.pop_front();
				compare_result(out_data, want);
			end
		end
	end

	// Drive out_ready: long hold-off on request, else short random stall bursts
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_stalls_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Offer one item, hold it until accepted, then predict its report
	task automatic send_tick_item(dcw_pkg::in_item_t item);
		if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		supervise_tick(item);
		if (item.tick_due)
			ticks_sent++;
	endtask

	// Drop valid and wait until every predicted report has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; call only while idle
	task automatic write_config(logic [15:0] timeout_val, logic [15:0] period_val);
		cfg_we <= 1'b1;
		cfg_index <= dcw_pkg::CFG_TIMEOUT_TICKS;
		cfg_data <= timeout_val;
		@(posedge clk);
		cfg_index <= dcw_pkg::CFG_LED_PERIOD;
		cfg_data <= period_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_timeout = timeout_val;
		reg_led_period = period_val;
	endtask

	function automatic dcw_pkg::in_item_t make_item(logic tick, logic valid, logic [2:0] cmd,
			logic [47:0] sp);
		dcw_pkg::in_item_t item;
		item.tick_due = tick;
		item.cmd_valid = valid;
		item.command = cmd;
		item.setpoint_in = sp;
		return item;
	endfunction

	// Mostly ticks with known commands, some idle items and unknown codes
	function automatic dcw_pkg::in_item_t random_item(int cmd_pct);
		dcw_pkg::in_item_t item;
		logic [63:0]       bits;
		bits = {$urandom, $urandom};
		item.setpoint_in = bits[47:0];
		item.tick_due = ($urandom_range(0, 99) >= 8);
		item.cmd_valid = ($urandom_range(0, 99) < cmd_pct);
		if ($urandom_range(0, 9) == 0) begin
			item.command = 3'($urandom_range(0, 7));
		end else begin
			case ($urandom_range(0, 3))
				0: item.command = dcw_pkg::CMD_COAST;
				1: item.command = dcw_pkg::CMD_BRAKE;
				2: item.command = dcw_pkg::CMD_VELOCITY;
				default: item.command = dcw_pkg::CMD_HEADING;
			endcase
		end
		return item;
	endfunction

	// Offline ticks, ignored items, then every command code
	task automatic test_link_bringup();
		send_tick_item(make_item(1'b1, 1'b0, dcw_pkg::CMD_NONE, '0));
		send_tick_item(make_item(1'b0, 1'b1, dcw_pkg::CMD_VELOCITY, {48{1'b1}}));
		send_tick_item(make_item(1'b1, 1'b0, 3'd7, {48{1'b1}}));
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_VELOCITY, {48{1'b1}}));
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_HEADING, '0));
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_NONE, 48'h1234_5678_9ABC));
		send_tick_item(make_item(1'b1, 1'b1, 3'd5, 48'hFFFF_0000_FFFF));
		send_tick_item(make_item(1'b1, 1'b1, 3'd6, 48'h0000_FFFF_0000));
		send_tick_item(make_item(1'b1, 1'b1, 3'd7, {48{1'b1}}));
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_COAST, '0));
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_BRAKE, '0));
		settle();
	endtask

	// Let an enabled velocity drive go stale, then recover with a brake
	task automatic test_timeout_failsafe();
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_VELOCITY, 48'hA5A5_5A5A_0FF0));
		repeat (12) send_tick_item(make_item(1'b1, 1'b0, dcw_pkg::CMD_NONE, '0));
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_BRAKE, '0));
		settle();
	endtask

	// Zero, maximum and unit timeout and LED period
	task automatic test_register_extremes();
		write_config(16'd0, 16'd0);
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_HEADING, 48'h0000_FFFF_0000));
		send_tick_item(make_item(1'b1, 1'b0, dcw_pkg::CMD_NONE, '0));
		send_tick_item(make_item(1'b0, 1'b0, dcw_pkg::CMD_NONE, '0));
		send_tick_item(make_item(1'b1, 1'b0, dcw_pkg::CMD_NONE, '0));
		settle();
		write_config(16'hFFFF, 16'hFFFF);
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_VELOCITY, 48'h8000_0000_0001));
		repeat (4) send_tick_item(make_item(1'b1, 1'b0, dcw_pkg::CMD_NONE, '0));
		settle();
		write_config(16'd1, 16'd1);
		send_tick_item(make_item(1'b1, 1'b1, dcw_pkg::CMD_VELOCITY, 48'h7FFF_FFFF_FFFE));
		repeat (3) send_tick_item(make_item(1'b1, 1'b0, dcw_pkg::CMD_NONE, '0));
		settle();
	endtask

	// Hold the output off long enough that the input stalls
	task automatic test_output_backpressure();
		int target;
		target = ticks_sent + 24;
		hold_request = 1'b1;
		while (ticks_sent < target)
			send_tick_item(random_item(40));
		settle();
	endtask

	// Random phases with fresh register settings; last phase runs without idling
	task automatic test_random_traffic(int ticks_wanted);
		int          per_phase;
		int          cmd_pct;
		int          target;
		logic [15:0] timeout_val;
		logic [15:0] period_val;
		per_phase = ticks_wanted / 7;
		for (int phase = 0; phase < 7; phase++) begin
			settle();
			case ($urandom_range(0, 5))
				0: timeout_val = 16'd0;
				1: timeout_val = 16'hFFFF;
				default: timeout_val = 16'($urandom_range(1, 25));
			endcase
			case ($urandom_range(0, 5))
				0: period_val = 16'd0;
				1: period_val = 16'hFFFF;
				2: period_val = 16'd1;
				default: period_val = 16'($urandom_range(2, 40));
			endcase
			write_config(timeout_val, period_val);
			cmd_pct = $urandom_range(5, 60);
			target = ticks_sent + per_phase;
			while (ticks_sent < target) begin
				if (phase == 6) begin
					sender_gaps_on = 1'b0;
					receiver_stalls_on = 1'b0;
				end else if (ticks_sent % 32 == 0) begin
					sender_gaps_on = ($urandom_range(0, 3) != 0);
					receiver_stalls_on = ($urandom_range(0, 3) != 0);
				end
				send_tick_item(random_item(cmd_pct));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_link_bringup();
		test_timeout_failsafe();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic(820);
		settle();
		if (expected_ticks.size() != 0)
			report_mismatch("reports never delivered", 64'(expected_ticks.size()), '0);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/dcw_pkg.sv
src/dcw_led_div.sv
src/drive_command_watchdog.sv
src/dcw_checker.sv
tb/testbench.sv
